[rtl/core/nav_word_parity_encoder_macros.svh]
// assertion macros shared by the navigation word encoder rtl
`ifndef NAV_WORD_PARITY_ENCODER_MACROS_SVH
`define NAV_WORD_PARITY_ENCODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define NWPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define NWPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/nwpe_pkg.sv]
// types, constants and parity tables of the navigation word encoder
`timescale 1ns / 1ps

package nwpe_pkg;

  typedef enum logic [1:0] {
    KIND_TLM  = 2'd0,
    KIND_HOW  = 2'd1,
    KIND_DATA = 2'd2
  } kind_e;

  localparam logic [7:0]  PREAMBLE     = 8'h8b;
  localparam logic [17:0] TOW_WRAP     = 18'd100800;
  localparam logic [5:0]  D30_STAR_PAR = 6'h15;
  localparam logic [5:0]  D29_STAR_PAR = 6'h29;

  // parity contribution of each data nibble, nibble 0 holds d21..d24
  localparam logic [5:0] PAR_TAB [6][16] = '{
    '{6'h00, 6'h13, 6'h25, 6'h36, 6'h0B, 6'h18, 6'h2E, 6'h3D,
      6'h16, 6'h05, 6'h33, 6'h20, 6'h1D, 6'h0E, 6'h38, 6'h2B},
    '{6'h00, 6'h2C, 6'h19, 6'h35, 6'h32, 6'h1E, 6'h2B, 6'h07,
      6'h26, 6'h0A, 6'h3F, 6'h13, 6'h14, 6'h38, 6'h0D, 6'h21},
    '{6'h00, 6'h0E, 6'h1F, 6'h11, 6'h3E, 6'h30, 6'h21, 6'h2F,
      6'h3D, 6'h33, 6'h22, 6'h2C, 6'h03, 6'h0D, 6'h1C, 6'h12},
    '{6'h00, 6'h38, 6'h31, 6'h09, 6'h23, 6'h1B, 6'h12, 6'h2A,
      6'h07, 6'h3F, 6'h36, 6'h0E, 6'h24, 6'h1C, 6'h15, 6'h2D},
    '{6'h00, 6'h0D, 6'h1A, 6'h17, 6'h37, 6'h3A, 6'h2D, 6'h20,
      6'h2F, 6'h22, 6'h35, 6'h38, 6'h18, 6'h15, 6'h02, 6'h0F},
    '{6'h00, 6'h1C, 6'h3B, 6'h27, 6'h34, 6'h28, 6'h0F, 6'h13,
      6'h2A, 6'h36, 6'h11, 6'h0D, 6'h1E, 6'h02, 6'h25, 6'h39}
  };

  // xor pattern over d23, d24 and the parity that zeroes D29 and D30
  function automatic logic [7:0] adjust_pattern(input logic [1:0] tail);
    logic [7:0] pat;
    unique case (tail)
      2'd0:    pat = 8'h00;
      2'd1:    pat = 8'ha5;
      2'd2:    pat = 8'hf6;
      default: pat = 8'h53;
    endcase
    return pat;
  endfunction

endpackage

[rtl/core/nwpe_in_if.sv]
// request channel of the navigation word encoder
`timescale 1ns / 1ps

interface nwpe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [23:0] data_bits;
  logic [16:0] tow_count;
  logic [2:0]  subframe_id;
  logic [9:0]  week_number;
  logic        insert_week;
  logic        last_of_subframe;

  modport source (
    output valid, kind, data_bits, tow_count, subframe_id, week_number,
           insert_week, last_of_subframe,
    input  ready
  );

  modport sink (
    input  valid, kind, data_bits, tow_count, subframe_id, week_number,
           insert_week, last_of_subframe,
    output ready
  );
endinterface

[rtl/core/nwpe_out_if.sv]
// result channel of the navigation word encoder
`timescale 1ns / 1ps

interface nwpe_out_if;
  logic        valid;
  logic        ready;
  logic [29:0] nav_word;

  modport source (
    output valid, nav_word,
    input  ready
  );

  modport sink (
    input  valid, nav_word,
    output ready
  );
endinterface

[rtl/core/nwpe_parity.sv]
// six hamming parity bits over d1..d24 and the previous word's D29/D30
`timescale 1ns / 1ps

module nwpe_parity (
  input  logic [1:0]  tail_i,
  input  logic [23:0] data_i,
  output logic [5:0]  parity_o
);

  always_comb begin
    logic [5:0] acc;
    acc = '0;
    for (int i = 0; i < 6; i++) begin
      acc ^= nwpe_pkg::PAR_TAB[i][data_i[4*i +: 4]];
    end
    if (tail_i[0]) begin
      acc ^= nwpe_pkg::D30_STAR_PAR;
    end
    if (tail_i[1]) begin
      acc ^= nwpe_pkg::D29_STAR_PAR;
    end
    parity_o = acc;
  end

endmodule

[rtl/core/nav_word_parity_encoder.sv]
// top level of the navigation word encoder
//
//   channel  dir  payload                                     handshake
//   in_i     in   kind, data_bits, tow_count, subframe_id,    valid/ready
//                 week_number, insert_week, last_of_subframe
//   out_o    out  nav_word                                    valid/ready
//
// one word per cycle sustained while out_o is ready
// the input register feeds word build and parity, then the result register
// the only feedback is D29/D30 of the last word, kept beside the result register
// reset clears both valid flags and that tail; the block is ready right after reset
// with the result stalled one more transaction is held in the input register
`timescale 1ns / 1ps

module nav_word_parity_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  nwpe_in_if.sink    in_i,
  nwpe_out_if.source out_o
);

`include "nav_word_parity_encoder_macros.svh"

  // input register
  logic        s1_valid_q;
  logic [1:0]  kind_q;
  logic [23:0] data_q;
  logic [16:0] tow_q;
  logic [2:0]  sf_q;
  logic [9:0]  week_q;
  logic        ins_q;
  logic        last_q;

  // result register and parity tail
  logic        out_valid_q, out_valid_d;
  logic [29:0] out_word_q;
  logic [1:0]  tail_q;

  logic        s1_adv;
  logic        in_acc;

  // combinational word build
  logic [17:0] tow_inc;
  logic [16:0] tow_next;
  logic [23:0] data_word;
  logic [23:0] raw;
  logic [23:0] body;
  logic [1:0]  tail_use;
  logic        adjust;
  logic [5:0]  parity;
  logic [29:0] word;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  assign out_o.valid    = out_valid_q;
  assign out_o.nav_word = out_word_q;

  always_comb begin
    tow_inc   = {1'b0, tow_q} + 18'd1;
    tow_next  = (tow_inc >= nwpe_pkg::TOW_WRAP) ? '0 : tow_inc[16:0];
    data_word = data_q | (ins_q ? {week_q, 14'd0} : 24'd0);
    unique case (nwpe_pkg::kind_e'(kind_q))
      nwpe_pkg::KIND_TLM: begin
        tail_use = 2'd0;
        raw      = {nwpe_pkg::PREAMBLE, 16'd0};
        adjust   = 1'b0;
      end
      nwpe_pkg::KIND_HOW: begin
        tail_use = tail_q;
        raw      = {tow_next, 2'd0, sf_q, 2'd0};
        adjust   = 1'b1;
      end
      nwpe_pkg::KIND_DATA: begin
        tail_use = tail_q;
        raw      = data_word;
        adjust   = last_q;
      end
      // unused code behaves as a data word
      default: begin
        tail_use = tail_q;
        raw      = data_word;
        adjust   = last_q;
      end
    endcase
    // a set D30 in the tail in use inverts d1..d24; TLM words use a zero tail
    body = raw ^ {24{tail_use[0]}};
  end

  nwpe_parity u_parity (
    .tail_i   (tail_use),
    .data_i   (body),
    .parity_o (parity)
  );

  always_comb begin
    word = {body, parity};
    if (adjust) begin
      word[7:0] = word[7:0] ^ nwpe_pkg::adjust_pattern(parity[1:0]);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tail_q      <= 2'd0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        tail_q <= word[1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= in_i.kind;
      data_q <= in_i.data_bits;
      tow_q  <= in_i.tow_count;
      sf_q   <= in_i.subframe_id;
      week_q <= in_i.week_number;
      ins_q  <= in_i.insert_week;
      last_q <= in_i.last_of_subframe;
    end
    if (s1_adv) begin
      out_word_q <= word;
    end
  end

  // a stalled result with a held transaction blocks the input
  `NWPE_ASSERT_NOW(a_stall_blocks_in, clk_i, rst_ni,
    s1_valid_q && out_valid_q && !out_o.ready, !in_i.ready, "input ready during full stall")

  // the kept tail always matches the word just loaded
  `NWPE_ASSERT_NEXT(a_tail_tracks_out, clk_i, rst_ni,
    s1_adv, tail_q == out_word_q[1:0], "parity tail differs from last word")

  // adjusted words end with D29 and D30 clear
  `NWPE_ASSERT_NEXT(a_adjust_zero_tail, clk_i, rst_ni,
    s1_adv && adjust, out_word_q[1:0] == 2'd0, "adjusted word has nonzero D29/D30")

endmodule
